[rtl/core/pcsp_pkg.sv]
// ----------------------------------------------------------------------------
// pcsp_pkg
// Shared types and character constants for the conversion spec parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pcsp_pkg;

  localparam int unsigned NUM_W = 31;   // width of the numeric result fields
  localparam int unsigned LEN_W = 8;    // width of the consumed length field

  // Parsing phase, one-hot.
  typedef enum logic [3:0] {
    PH_FLAGS = 4'b0001,
    PH_WIDTH = 4'b0010,
    PH_DOT   = 4'b0100,
    PH_PREC  = 4'b1000
  } phase_t;

  // Minus mode codes.
  localparam logic [1:0] MINUS_NONE = 2'd0;
  localparam logic [1:0] MINUS_FLAG = 2'd1;
  localparam logic [1:0] MINUS_STAR = 2'd2;

  // Conversion codes.
  localparam logic [3:0] CONV_NONE    = 4'd0;
  localparam logic [3:0] CONV_C       = 4'd1;
  localparam logic [3:0] CONV_S       = 4'd2;
  localparam logic [3:0] CONV_P       = 4'd3;
  localparam logic [3:0] CONV_D       = 4'd4;
  localparam logic [3:0] CONV_I       = 4'd5;
  localparam logic [3:0] CONV_U       = 4'd6;
  localparam logic [3:0] CONV_X_LOW   = 4'd7;
  localparam logic [3:0] CONV_X_UP    = 4'd8;
  localparam logic [3:0] CONV_PERCENT = 4'd9;

  // Flag bit positions within the flag vector.
  localparam logic [3:0] FLAG_HASH  = 4'b0001;
  localparam logic [3:0] FLAG_PLUS  = 4'b0010;
  localparam logic [3:0] FLAG_SPACE = 4'b0100;
  localparam logic [3:0] FLAG_ZERO  = 4'b1000;

  // Characters.
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_C       = 8'h63;
  localparam logic [7:0] CH_S       = 8'h73;
  localparam logic [7:0] CH_P       = 8'h70;
  localparam logic [7:0] CH_D       = 8'h64;
  localparam logic [7:0] CH_I       = 8'h69;
  localparam logic [7:0] CH_U       = 8'h75;
  localparam logic [7:0] CH_X_LOW   = 8'h78;
  localparam logic [7:0] CH_X_UP    = 8'h58;
  localparam logic [7:0] CH_PERCENT = 8'h25;

  // Control part of the parser state.
  typedef struct packed {
    phase_t     phase;
    logic [3:0] flag_bits;
    logic [1:0] minus_state;
    logic       prec_given;
    logic       prec_neg;
    logic       star_lock;
  } ctl_t;

  localparam ctl_t CTL_CLEAR = '{
    phase:       PH_FLAGS,
    flag_bits:   4'b0000,
    minus_state: MINUS_NONE,
    prec_given:  1'b0,
    prec_neg:    1'b0,
    star_lock:   1'b0
  };

  // One finished conversion spec.
  typedef struct packed {
    logic             flag_hash;
    logic             flag_plus;
    logic             flag_space;
    logic [1:0]       minus_mode;
    logic             flag_zero;
    logic [NUM_W-1:0] field_width;
    logic             precision_given;
    logic [NUM_W-1:0] precision_value;
    logic             precision_negative;
    logic [3:0]       conv_code;
    logic             unresolved;
    logic [LEN_W-1:0] consumed_len;
  } result_t;

endpackage

`default_nettype wire

[rtl/core/pcsp_if.sv]
// ----------------------------------------------------------------------------
// pcsp_if
// Valid/ready channels for format characters and for finished specs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface pcsp_char_if;
  logic              valid;
  logic              ready;
  logic [7:0]        ch;
  logic signed [31:0] star_value;

  modport source(output valid, ch, star_value, input ready);
  modport sink(input valid, ch, star_value, output ready);
endinterface

interface pcsp_spec_if;
  logic                           valid;
  logic                           ready;
  logic                           flag_hash;
  logic                           flag_plus;
  logic                           flag_space;
  logic [1:0]                     minus_mode;
  logic                           flag_zero;
  logic [pcsp_pkg::NUM_W-1:0]     field_width;
  logic                           precision_given;
  logic [pcsp_pkg::NUM_W-1:0]     precision_value;
  logic                           precision_negative;
  logic [3:0]                     conv_code;
  logic                           unresolved;
  logic [pcsp_pkg::LEN_W-1:0]     consumed_len;

  modport source(output valid, flag_hash, flag_plus, flag_space, minus_mode, flag_zero,
                 field_width, precision_given, precision_value, precision_negative,
                 conv_code, unresolved, consumed_len, input ready);
  modport sink(input valid, flag_hash, flag_plus, flag_space, minus_mode, flag_zero,
               field_width, precision_given, precision_value, precision_negative,
               conv_code, unresolved, consumed_len, output ready);
endinterface

`default_nettype wire

[rtl/core/printf_conversion_spec_parser_top.sv]
// A terminating character waits in the input stage register; its result is
// written to the result register once that is free and is then offered on specs.
// Throughput: one character per cycle unless a terminator waits on a full result
// register; the parse state updates through combinational logic between registers.
// Reset clears the parse state and both valid flags; no result is pending.
// ----------------------------------------------------------------------------
// printf_conversion_spec_parser_top
// Parses the characters after a percent sign into one conversion spec.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module printf_conversion_spec_parser_top #(
  parameter int unsigned NUM_BITS = 31,
  parameter int unsigned LEN_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  pcsp_char_if.sink          chars,
  pcsp_spec_if.source        specs
);

  // Input stage.
  logic                s1_valid;
  logic [7:0]          s1_ch;
  logic signed [31:0]  s1_star;

  // Parse state.
  pcsp_pkg::ctl_t      ctl;
  logic [NUM_BITS-1:0] width_acc;
  logic [NUM_BITS-1:0] prec_acc;
  logic [LEN_BITS-1:0] char_count;

  // Parse logic outputs.
  pcsp_pkg::ctl_t      ctl_next;
  logic [NUM_BITS-1:0] width_next;
  logic [NUM_BITS-1:0] prec_next;
  logic [LEN_BITS-1:0] count_next;
  logic                emit;
  pcsp_pkg::result_t   res_next;

  // Result stage.
  logic                out_valid;
  pcsp_pkg::result_t   out_res;

  logic                out_free;
  logic                s1_fire;
  logic                in_fire;

  assign out_free     = !out_valid || specs.ready;
  assign s1_fire      = s1_valid && (!emit || out_free);
  assign chars.ready  = !s1_valid || s1_fire;
  assign in_fire      = chars.valid && chars.ready;

  pcsp_parse #(
    .NUM_BITS (NUM_BITS),
    .LEN_BITS (LEN_BITS)
  ) u_parse (
    .ch         (s1_ch),
    .star_value (s1_star),
    .ctl        (ctl),
    .width_acc  (width_acc),
    .prec_acc   (prec_acc),
    .char_count (char_count),
    .ctl_next   (ctl_next),
    .width_next (width_next),
    .prec_next  (prec_next),
    .count_next (count_next),
    .emit       (emit),
    .res        (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (chars.ready) begin
      s1_valid <= chars.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_ch   <= chars.ch;
      s1_star <= chars.star_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl        <= pcsp_pkg::CTL_CLEAR;
      width_acc  <= '0;
      prec_acc   <= '0;
      char_count <= '0;
    end else if (s1_fire) begin
      ctl        <= ctl_next;
      width_acc  <= width_next;
      prec_acc   <= prec_next;
      char_count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && emit) begin
      out_valid <= 1'b1;
    end else if (specs.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && emit) begin
      out_res <= res_next;
    end
  end

  assign specs.valid              = out_valid;
  assign specs.flag_hash          = out_res.flag_hash;
  assign specs.flag_plus          = out_res.flag_plus;
  assign specs.flag_space         = out_res.flag_space;
  assign specs.minus_mode         = out_res.minus_mode;
  assign specs.flag_zero          = out_res.flag_zero;
  assign specs.field_width        = out_res.field_width;
  assign specs.precision_given    = out_res.precision_given;
  assign specs.precision_value    = out_res.precision_value;
  assign specs.precision_negative = out_res.precision_negative;
  assign specs.conv_code          = out_res.conv_code;
  assign specs.unresolved         = out_res.unresolved;
  assign specs.consumed_len       = out_res.consumed_len;

  // A terminating character always leaves a fresh spec behind.
  a_clear_after_emit: assert property (@(posedge clk) disable iff (rst)
    s1_fire && emit |=> (ctl == pcsp_pkg::CTL_CLEAR) && (char_count == '0)
      && (width_acc == '0) && (prec_acc == '0))
    else $error("parse state not cleared after a terminating item");

  // The input stage only holds when its result cannot be written.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_fire |-> emit && out_valid && !specs.ready)
    else $error("input stage stalled without a blocked result");

  // A known specifier is never also unresolved.
  a_conv_unresolved: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !((out_res.conv_code != pcsp_pkg::CONV_NONE) && out_res.unresolved))
    else $error("result has both a conversion code and the unresolved mark");

  // A negative star precision implies a precision part with value zero.
  a_prec_neg: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.precision_negative |->
      out_res.precision_given && (out_res.precision_value == '0))
    else $error("negative precision without precision part or with nonzero value");

  // Minus mode never takes the unused code.
  a_minus_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_res.minus_mode == pcsp_pkg::MINUS_NONE)
      || (out_res.minus_mode == pcsp_pkg::MINUS_FLAG)
      || (out_res.minus_mode == pcsp_pkg::MINUS_STAR))
    else $error("minus mode holds an unused code");

endmodule

`default_nettype wire

[rtl/core/pcsp_parse.sv]
// ----------------------------------------------------------------------------
// pcsp_parse
// Next-state and result logic for one format character.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pcsp_parse #(
  parameter int unsigned NUM_BITS = 31,
  parameter int unsigned LEN_BITS = 8
) (
  input  logic [7:0]              ch,
  input  logic signed [31:0]      star_value,
  input  pcsp_pkg::ctl_t          ctl,
  input  logic [NUM_BITS-1:0]     width_acc,
  input  logic [NUM_BITS-1:0]     prec_acc,
  input  logic [LEN_BITS-1:0]     char_count,
  output pcsp_pkg::ctl_t          ctl_next,
  output logic [NUM_BITS-1:0]     width_next,
  output logic [NUM_BITS-1:0]     prec_next,
  output logic [LEN_BITS-1:0]     count_next,
  output logic                    emit,
  output pcsp_pkg::result_t       res
);

  localparam int unsigned MUL_W = NUM_BITS + 4;
  localparam int unsigned CNT_W = (LEN_BITS > pcsp_pkg::LEN_W) ? LEN_BITS : pcsp_pkg::LEN_W;
  localparam logic [NUM_BITS-1:0] NUM_MAX = '1;
  localparam logic [LEN_BITS-1:0] LEN_MAX = '1;
  localparam logic [CNT_W-1:0]    OUT_LEN_MAX = CNT_W'({pcsp_pkg::LEN_W{1'b1}});

  logic                is_digit;
  logic [MUL_W-1:0]    digit_ext;
  logic                star_neg;
  logic [31:0]         star_mag;
  logic [NUM_BITS-1:0] star_sat;
  logic [MUL_W-1:0]    width_x10;
  logic [MUL_W-1:0]    prec_x10;
  logic [NUM_BITS-1:0] width_dig;
  logic [NUM_BITS-1:0] prec_dig;
  logic [LEN_BITS-1:0] count_inc;
  logic [LEN_BITS-1:0] count_fin;
  logic [CNT_W-1:0]    count_wide;
  logic [3:0]          flag_bit;
  logic [3:0]          conv;
  logic                in_flags;
  logic                in_width;
  logic                in_dot;
  logic                in_prec;

  assign is_digit  = (ch >= pcsp_pkg::CH_ZERO) && (ch <= pcsp_pkg::CH_NINE);
  assign digit_ext = MUL_W'(ch[3:0]);
  assign star_neg  = star_value[31];
  assign star_mag  = star_neg ? 32'(-star_value) : 32'(star_value);
  assign star_sat  = (|star_mag[31:NUM_BITS]) ? NUM_MAX : star_mag[NUM_BITS-1:0];

  // Times ten as two shifted copies; saturate when any bit lands above the field.
  assign width_x10 = (MUL_W'(width_acc) << 3) + (MUL_W'(width_acc) << 1) + digit_ext;
  assign prec_x10  = (MUL_W'(prec_acc) << 3) + (MUL_W'(prec_acc) << 1) + digit_ext;
  assign width_dig = (|width_x10[MUL_W-1:NUM_BITS]) ? NUM_MAX : width_x10[NUM_BITS-1:0];
  assign prec_dig  = (|prec_x10[MUL_W-1:NUM_BITS]) ? NUM_MAX : prec_x10[NUM_BITS-1:0];

  assign count_inc = (char_count == LEN_MAX) ? char_count : char_count + 1'b1;

  assign in_flags = (ctl.phase == pcsp_pkg::PH_FLAGS);
  assign in_width = (ctl.phase == pcsp_pkg::PH_WIDTH);
  assign in_dot   = (ctl.phase == pcsp_pkg::PH_DOT);
  assign in_prec  = (ctl.phase == pcsp_pkg::PH_PREC);

  always_comb begin
    case (ch)
      pcsp_pkg::CH_HASH:  flag_bit = pcsp_pkg::FLAG_HASH;
      pcsp_pkg::CH_PLUS:  flag_bit = pcsp_pkg::FLAG_PLUS;
      pcsp_pkg::CH_SPACE: flag_bit = pcsp_pkg::FLAG_SPACE;
      pcsp_pkg::CH_ZERO:  flag_bit = pcsp_pkg::FLAG_ZERO;
      default:            flag_bit = 4'b0000;
    endcase
  end

  always_comb begin
    case (ch)
      pcsp_pkg::CH_C:       conv = pcsp_pkg::CONV_C;
      pcsp_pkg::CH_S:       conv = pcsp_pkg::CONV_S;
      pcsp_pkg::CH_P:       conv = pcsp_pkg::CONV_P;
      pcsp_pkg::CH_D:       conv = pcsp_pkg::CONV_D;
      pcsp_pkg::CH_I:       conv = pcsp_pkg::CONV_I;
      pcsp_pkg::CH_U:       conv = pcsp_pkg::CONV_U;
      pcsp_pkg::CH_X_LOW:   conv = pcsp_pkg::CONV_X_LOW;
      pcsp_pkg::CH_X_UP:    conv = pcsp_pkg::CONV_X_UP;
      pcsp_pkg::CH_PERCENT: conv = pcsp_pkg::CONV_PERCENT;
      default:              conv = pcsp_pkg::CONV_NONE;
    endcase
  end

  // A character that does not fit the current phase falls through to the
  // next phase's checks in the same cycle, and finally terminates the spec.
  always_comb begin
    ctl_next   = ctl;
    width_next = width_acc;
    prec_next  = prec_acc;
    count_next = count_inc;
    emit       = 1'b0;
    if (in_flags && (flag_bit != 4'b0000)) begin
      ctl_next.flag_bits = ctl.flag_bits | flag_bit;
    end else if (in_flags && (ch == pcsp_pkg::CH_MINUS)) begin
      ctl_next.minus_state = pcsp_pkg::MINUS_FLAG;
    end else if (in_flags && (ch == pcsp_pkg::CH_STAR)) begin
      if (star_neg && (ctl.minus_state == pcsp_pkg::MINUS_NONE)) begin
        ctl_next.minus_state = pcsp_pkg::MINUS_STAR;
      end
      width_next         = star_sat;
      ctl_next.star_lock = 1'b1;
      ctl_next.phase     = pcsp_pkg::PH_WIDTH;
    end else if ((in_flags || in_width) && is_digit && !ctl.star_lock) begin
      width_next     = width_dig;
      ctl_next.phase = pcsp_pkg::PH_WIDTH;
    end else if ((in_flags || in_width) && (ch == pcsp_pkg::CH_DOT)) begin
      ctl_next.prec_given = 1'b1;
      ctl_next.star_lock  = 1'b0;
      ctl_next.phase      = pcsp_pkg::PH_DOT;
    end else if (in_dot && (ch == pcsp_pkg::CH_STAR)) begin
      if (star_neg) begin
        prec_next         = '0;
        ctl_next.prec_neg = 1'b1;
      end else begin
        prec_next = star_sat;
      end
      ctl_next.star_lock = 1'b1;
      ctl_next.phase     = pcsp_pkg::PH_PREC;
    end else if ((in_dot || in_prec) && is_digit && !ctl.star_lock) begin
      prec_next      = prec_dig;
      ctl_next.phase = pcsp_pkg::PH_PREC;
    end else begin
      emit       = 1'b1;
      ctl_next   = pcsp_pkg::CTL_CLEAR;
      width_next = '0;
      prec_next  = '0;
      count_next = '0;
    end
  end

  // The result is built from the state before this character.
  assign count_fin  = (conv != pcsp_pkg::CONV_NONE) ? count_inc : char_count;
  assign count_wide = CNT_W'(count_fin);

  always_comb begin
    res.flag_hash          = ctl.flag_bits[0];
    res.flag_plus          = ctl.flag_bits[1];
    res.flag_space         = ctl.flag_bits[2];
    res.minus_mode         = ctl.minus_state;
    res.flag_zero          = ctl.flag_bits[3];
    res.field_width        = pcsp_pkg::NUM_W'(width_acc);
    res.precision_given    = ctl.prec_given;
    res.precision_value    = pcsp_pkg::NUM_W'(prec_acc);
    res.precision_negative = ctl.prec_neg;
    res.conv_code          = conv;
    res.unresolved         = (conv == pcsp_pkg::CONV_NONE) && (ch != pcsp_pkg::CH_NUL);
    res.consumed_len       = (count_wide > OUT_LEN_MAX) ? pcsp_pkg::LEN_W'(OUT_LEN_MAX)
                                                        : count_wide[pcsp_pkg::LEN_W-1:0];
  end

endmodule

`default_nettype wire

[tb/pcsp_spec_checker.sv]
// ----------------------------------------------------------------------------
// pcsp_spec_checker
// Watches the character and spec channels of the conversion spec parser.
// It keeps its own copy of the parse state, predicts the spec that each
// accepted character ends, and compares every accepted spec with the oldest
// prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcsp_spec_checker (
  input  logic clk,
  input  logic rst,
  pcsp_char_if chars,
  pcsp_spec_if specs,
  output int   mismatches,
  output int   specs_pending
);
  import pcsp_pkg::*;

  localparam logic [63:0]      NUM_MAX = (64'd1 << NUM_W) - 64'd1;
  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  phase_t           cur_phase;
  logic [3:0]       flag_acc;
  logic [1:0]       minus_acc;
  logic [NUM_W-1:0] width_acc;
  logic [NUM_W-1:0] prec_acc;
  logic             prec_given;
  logic             prec_neg;
  logic             star_lock;
  logic [LEN_W-1:0] char_cnt;
  result_t          spec_queue[$];

  initial begin
    mismatches    = 0;
    specs_pending = 0;
  end

  function automatic logic [NUM_W-1:0] clip_num(input logic [63:0] v);
    return (v > NUM_MAX) ? NUM_MAX[NUM_W-1:0] : v[NUM_W-1:0];
  endfunction

  function automatic logic [NUM_W-1:0] add_digit(input logic [NUM_W-1:0] acc,
                                                 input logic [7:0] d);
    return clip_num(64'(acc) * 64'd10 + 64'(d));
  endfunction

  task automatic restart_spec();
    cur_phase  = PH_FLAGS;
    flag_acc   = 4'b0000;
    minus_acc  = MINUS_NONE;
    width_acc  = '0;
    prec_acc   = '0;
    prec_given = 1'b0;
    prec_neg   = 1'b0;
    star_lock  = 1'b0;
    char_cnt   = '0;
  endtask

  task automatic count_char();
    if (char_cnt != LEN_MAX) begin
      char_cnt = char_cnt + 1'b1;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("%0t mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
    mismatches++;
  endtask

  // Advances the parse state by one character; a character that fits no part
  // of the spec ends it and queues the finished spec.
  task automatic parse_char(input logic [7:0] c, input logic [31:0] sv);
    logic        neg;
    logic [32:0] mag;
    logic        is_digit;
    logic        in_width;
    logic        in_prec;
    logic [3:0]  flag;
    logic [3:0]  conv;
    result_t     res;
    neg      = sv[31];
    mag      = neg ? (33'h1_0000_0000 - {1'b0, sv}) : {1'b0, sv};
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    in_width = (cur_phase == PH_FLAGS) || (cur_phase == PH_WIDTH);
    in_prec  = (cur_phase == PH_DOT) || (cur_phase == PH_PREC);
    case (c)
      CH_HASH:  flag = FLAG_HASH;
      CH_PLUS:  flag = FLAG_PLUS;
      CH_SPACE: flag = FLAG_SPACE;
      CH_ZERO:  flag = FLAG_ZERO;
      default:  flag = 4'b0000;
    endcase

    if (cur_phase == PH_FLAGS && flag != 4'b0000) begin
      flag_acc = flag_acc | flag;
      count_char();
    end else if (cur_phase == PH_FLAGS && c == CH_MINUS) begin
      minus_acc = MINUS_FLAG;
      count_char();
    end else if (cur_phase == PH_FLAGS && c == CH_STAR) begin
      // A negative star width only marks the minus mode if no '-' flag came.
      if (neg && minus_acc == MINUS_NONE) begin
        minus_acc = MINUS_STAR;
      end
      width_acc = clip_num(64'(mag));
      star_lock = 1'b1;
      cur_phase = PH_WIDTH;
      count_char();
    end else if (in_width && is_digit && !star_lock) begin
      width_acc = add_digit(width_acc, c - CH_ZERO);
      cur_phase = PH_WIDTH;
      count_char();
    end else if (in_width && c == CH_DOT) begin
      prec_given = 1'b1;
      prec_neg   = 1'b0;
      star_lock  = 1'b0;
      cur_phase  = PH_DOT;
      count_char();
    end else if (cur_phase == PH_DOT && c == CH_STAR) begin
      if (neg) begin
        prec_acc = '0;
        prec_neg = 1'b1;
      end else begin
        prec_acc = clip_num(64'(mag));
      end
      star_lock = 1'b1;
      cur_phase = PH_PREC;
      count_char();
    end else if (in_prec && is_digit && !star_lock) begin
      prec_acc  = add_digit(prec_acc, c - CH_ZERO);
      cur_phase = PH_PREC;
      count_char();
    end else begin
      case (c)
        CH_C:       conv = CONV_C;
        CH_S:       conv = CONV_S;
        CH_P:       conv = CONV_P;
        CH_D:       conv = CONV_D;
        CH_I:       conv = CONV_I;
        CH_U:       conv = CONV_U;
        CH_X_LOW:   conv = CONV_X_LOW;
        CH_X_UP:    conv = CONV_X_UP;
        CH_PERCENT: conv = CONV_PERCENT;
        default:    conv = CONV_NONE;
      endcase
      if (conv != CONV_NONE) begin
        count_char();
      end
      res.flag_hash          = |(flag_acc & FLAG_HASH);
      res.flag_plus          = |(flag_acc & FLAG_PLUS);
      res.flag_space         = |(flag_acc & FLAG_SPACE);
      res.minus_mode         = minus_acc;
      res.flag_zero          = |(flag_acc & FLAG_ZERO);
      res.field_width        = width_acc;
      res.precision_given    = prec_given;
      res.precision_value    = prec_acc;
      res.precision_negative = prec_neg;
      res.conv_code          = conv;
      res.unresolved         = (conv == CONV_NONE) && (c != CH_NUL);
      res.consumed_len       = char_cnt;
      spec_queue.push_back(res);
      restart_spec();
    end
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      restart_spec();
      spec_queue.delete();
    end else begin
      // A spec leaving now belongs to a character taken at an earlier edge,
      // so it is checked before this edge's character is parsed.
      if (specs.valid && specs.ready) begin
        if (spec_queue.size() == 0) begin
          report_mismatch("spec with none pending", 32'd0, 32'd1);
        end else begin
          want = spec_queue.pop_front();
          if (specs.flag_hash !== want.flag_hash)
            report_mismatch("flag_hash", want.flag_hash, specs.flag_hash);
          if (specs.flag_plus !== want.flag_plus)
            report_mismatch("flag_plus", want.flag_plus, specs.flag_plus);
          if (specs.flag_space !== want.flag_space)
            report_mismatch("flag_space", want.flag_space, specs.flag_space);
          if (specs.minus_mode !== want.minus_mode)
            report_mismatch("minus_mode", want.minus_mode, specs.minus_mode);
          if (specs.flag_zero !== want.flag_zero)
            report_mismatch("flag_zero", want.flag_zero, specs.flag_zero);
          if (specs.field_width !== want.field_width)
            report_mismatch("field_width", want.field_width, specs.field_width);
          if (specs.precision_given !== want.precision_given)
            report_mismatch("precision_given", want.precision_given,
                            specs.precision_given);
          if (specs.precision_value !== want.precision_value)
            report_mismatch("precision_value", want.precision_value,
                            specs.precision_value);
          if (specs.precision_negative !== want.precision_negative)
            report_mismatch("precision_negative", want.precision_negative,
                            specs.precision_negative);
          if (specs.conv_code !== want.conv_code)
            report_mismatch("conv_code", want.conv_code, specs.conv_code);
          if (specs.unresolved !== want.unresolved)
            report_mismatch("unresolved", want.unresolved, specs.unresolved);
          if (specs.consumed_len !== want.consumed_len)
            report_mismatch("consumed_len", want.consumed_len, specs.consumed_len);
        end
      end
      if (chars.valid && chars.ready) begin
        parse_char(chars.ch, chars.star_value);
      end
    end
    specs_pending <= spec_queue.size();
  end

endmodule

[tb/printf_conversion_spec_parser_top_tb.sv]
// ----------------------------------------------------------------------------
// printf_conversion_spec_parser_top_tb
// Feeds format characters to the conversion spec parser: a directed run over
// flags, star widths and precisions, unresolved and NUL endings, then random
// specs mixed with noise, under random idling on both channels and long
// receiver hold-offs. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module printf_conversion_spec_parser_top_tb;
  import pcsp_pkg::*;

  logic clk = 1'b0;
  logic rst;
  int   mismatches;
  int   specs_pending;
  int   items_sent = 0;
  bit   calm = 1'b0;
  bit   hold_now = 1'b0;
  bit   long_done = 1'b0;

  pcsp_char_if chars();
  pcsp_spec_if specs();

  printf_conversion_spec_parser_top i_dut (
    .clk   (clk),
    .rst   (rst),
    .chars (chars),
    .specs (specs)
  );

  pcsp_spec_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .chars         (chars),
    .specs         (specs),
    .mismatches    (mismatches),
    .specs_pending (specs_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] pick_flag();
    case ($urandom_range(0, 4))
      0:       return CH_HASH;
      1:       return CH_PLUS;
      2:       return CH_SPACE;
      3:       return CH_MINUS;
      default: return CH_ZERO;
    endcase
  endfunction

  function automatic logic [7:0] pick_digit();
    return 8'(CH_ZERO + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] pick_conv();
    case ($urandom_range(0, 8))
      0:       return CH_C;
      1:       return CH_S;
      2:       return CH_P;
      3:       return CH_D;
      4:       return CH_I;
      5:       return CH_U;
      6:       return CH_X_LOW;
      7:       return CH_X_UP;
      default: return CH_PERCENT;
    endcase
  endfunction

  function automatic logic [31:0] pick_star();
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1:       return 32'($urandom_range(0, 40)) - 32'd20;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      4:       return 32'hFFFF_FFFF;
      default: return 32'($urandom_range(0, 999));
    endcase
  endfunction

  // Offers one character, waits for the edge where it is taken, then at times idles.
  task automatic send_char(input logic [7:0] c, input logic [31:0] sv);
    chars.valid      <= 1'b1;
    chars.ch         <= c;
    chars.star_value <= sv;
    @(posedge clk);
    while (!chars.ready) @(posedge clk);
    items_sent++;
    if (items_sent == 60 || items_sent == 100) begin
      hold_now = 1'b1;
    end
    if (!calm && $urandom_range(0, 4) == 0) begin
      chars.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Digits for a width or precision; the long form can overflow and saturate.
  task automatic send_number();
    int n;
    n = ($urandom_range(0, 5) == 0) ? 11 : $urandom_range(1, 3);
    repeat (n) send_char(pick_digit(), $urandom);
  endtask

  task automatic send_random_spec();
    int r;
    if ($urandom_range(0, 9) == 0) begin
      // Noise: raw bytes of any value.
      repeat ($urandom_range(1, 4)) send_char(8'($urandom_range(0, 255)), $urandom);
    end else begin
      repeat ($urandom_range(0, 3)) send_char(pick_flag(), $urandom);
      case ($urandom_range(0, 2))
        1:       send_number();
        2:       send_char(CH_STAR, pick_star());
        default: ;
      endcase
      if ($urandom_range(0, 1) == 1) begin
        send_char(CH_DOT, $urandom);
        case ($urandom_range(0, 2))
          1:       send_number();
          2:       send_char(CH_STAR, pick_star());
          default: ;
        endcase
      end
      // Now and then a stray character that breaks the sequence.
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 3))
          0:       send_char(CH_STAR, pick_star());
          1:       send_char(pick_digit(), $urandom);
          2:       send_char(CH_DOT, $urandom);
          default: send_char(CH_MINUS, $urandom);
        endcase
      end
      r = $urandom_range(0, 9);
      if (r < 7) begin
        send_char(pick_conv(), $urandom);
      end else if (r == 7) begin
        send_char(CH_NUL, $urandom);
      end else begin
        send_char(8'($urandom_range(0, 255)), $urandom);
      end
    end
  endtask

  // Result side: random stalls, open stretches, and long hold-offs on request.
  initial begin
    specs.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_now) begin
        hold_now = 1'b0;
        specs.ready <= 1'b0;
        repeat (64) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        specs.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        specs.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  initial begin
    rst              <= 1'b1;
    chars.valid      <= 1'b0;
    chars.ch         <= CH_NUL;
    chars.star_value <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Bare specifier, then every flag ending in an upper-case hex.
    send_char(CH_D, $urandom);
    send_char(CH_HASH, $urandom);
    send_char(CH_PLUS, $urandom);
    send_char(CH_SPACE, $urandom);
    send_char(CH_MINUS, $urandom);
    send_char(CH_ZERO, $urandom);
    send_char(CH_X_UP, $urandom);
    // Negative star width turns into minus mode.
    send_char(CH_STAR, -32'sd5);
    send_char(CH_S, $urandom);
    // Minus flag wins over the most negative star width; negative precision.
    send_char(CH_MINUS, $urandom);
    send_char(CH_STAR, 32'h8000_0000);
    send_char(CH_DOT, $urandom);
    send_char(CH_STAR, 32'hFFFF_FFFF);
    send_char(CH_U, $urandom);
    // A digit after a star, and a star after digits, both end unresolved.
    send_char(CH_STAR, 32'd7);
    send_char(8'(CH_ZERO + 8'd5), $urandom);
    send_char(8'(CH_ZERO + 8'd3), $urandom);
    send_char(CH_STAR, 32'd9);
    // NUL ends a spec without a conversion.
    send_char(CH_DOT, $urandom);
    send_char(CH_NUL, $urandom);
    // Largest star precision.
    send_char(CH_DOT, $urandom);
    send_char(CH_STAR, 32'h7FFF_FFFF);
    send_char(CH_PERCENT, $urandom);
    send_char(CH_C, $urandom);
    send_char(CH_P, $urandom);
    send_char(CH_I, $urandom);

    while (items_sent < 400) begin
      if (!long_done && items_sent >= 120) begin
        // A flag run long enough to saturate the consumed length.
        long_done = 1'b1;
        repeat (270) send_char(pick_flag(), $urandom);
        send_char(pick_conv(), $urandom);
      end
      if (items_sent >= 360) begin
        calm = 1'b1;
      end
      send_random_spec();
    end

    chars.valid <= 1'b0;
    @(posedge clk);
    while (specs_pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS printf_conversion_spec_parser_top");
    end else begin
      $display("FAIL printf_conversion_spec_parser_top");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL printf_conversion_spec_parser_top");
    $finish;
  end

endmodule
